// File: rtl/bbc_pkg.sv
// Shared types, character, bracket, error and comment-mode codes and helper functions for the bracket checker.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package bbc_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int LINE_BITS_DEF   = 20;
	localparam int OUT_LINE_BITS   = 20;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_LSQ   = 8'h5B;
	localparam logic [7:0] CH_LCU   = 8'h7B;
	localparam logic [7:0] CH_LPA   = 8'h28;
	localparam logic [7:0] CH_RSQ   = 8'h5D;
	localparam logic [7:0] CH_RCU   = 8'h7D;
	localparam logic [7:0] CH_RPA   = 8'h29;

	// bracket codes kept on the stack
	localparam logic [1:0] BR_PAREN  = 2'd0;
	localparam logic [1:0] BR_SQUARE = 2'd1;
	localparam logic [1:0] BR_CURLY  = 2'd2;
	localparam logic [1:0] BR_NONE   = 2'd3;

	localparam logic [1:0] ERR_EMPTY    = 2'd0;
	localparam logic [1:0] ERR_MISMATCH = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	localparam logic [2:0] MODE_NORMAL     = 3'd0;
	localparam logic [2:0] MODE_SLASH      = 3'd1;
	localparam logic [2:0] MODE_LINE       = 3'd2;
	localparam logic [2:0] MODE_BLOCK      = 3'd3;
	localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;

	typedef struct packed {
		logic       text_start;
		logic [7:0] char_in;
	} item_t;

	typedef struct packed {
		logic [1:0]               error_kind;
		logic [OUT_LINE_BITS-1:0] line_number;
		logic [7:0]               found_char;
	} result_t;

	function automatic logic [1:0] opener_code(input logic [7:0] ch);
		case (ch)
			CH_LPA:  opener_code = BR_PAREN;
			CH_LSQ:  opener_code = BR_SQUARE;
			CH_LCU:  opener_code = BR_CURLY;
			default: opener_code = BR_NONE;
		endcase
	endfunction

	function automatic logic [1:0] closer_code(input logic [7:0] ch);
		case (ch)
			CH_RPA:  closer_code = BR_PAREN;
			CH_RSQ:  closer_code = BR_SQUARE;
			CH_RCU:  closer_code = BR_CURLY;
			default: closer_code = BR_NONE;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/bbc_out_slice.sv
// Output register with a skid entry, so the core keeps moving while a result waits.
// Depends on bbc_pkg for the result type.
`default_nettype none

module bbc_out_slice (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire bbc_pkg::result_t res,
	output logic                  res_ready,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output bbc_pkg::result_t      result
);

	logic             out_valid_q;
	bbc_pkg::result_t out_q;
	logic             skid_valid_q;
	bbc_pkg::result_t skid_q;
	logic             out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign res_ready    = !skid_valid_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbc_core.sv
// Input register, comment-mode tracking, line counter and bracket stack.
// Depends on bbc_pkg and bbc_ram; the stack top lives in a register, the rest in RAM.
`default_nettype none

module bbc_core #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
	parameter int LINE_BITS   = bbc_pkg::LINE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire bbc_pkg::item_t   item,
	input  wire logic             res_ready,
	output logic                  res_valid,
	output bbc_pkg::result_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic           item_valid_s1;
	bbc_pkg::item_t item_s1;
	logic           adv;

	logic [2:0]           mode_q, mode_b, mode_d;
	logic [CW-1:0]        cnt_q, cnt_b, cnt_d, cnt_nx, cnt_m1, rd_tmp;
	logic [LINE_BITS-1:0] line_q, line_b, line_d;
	logic [1:0]           top_q, top_d, below, rdata;
	logic                 byp_flag_q;
	logic [1:0]           byp_q;

	logic [7:0] ch;
	logic [1:0] oc, cc;
	logic       is_text, push, we_c, err_v;
	logic [1:0] err_k;
	logic [31:0] line_ext;

	assign adv        = item_valid_s1 && res_ready;
	assign item_stall = item_valid_s1 && !res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign ch = item_s1.char_in;
	assign oc = bbc_pkg::opener_code(ch);
	assign cc = bbc_pkg::closer_code(ch);
	// a push last cycle wrote the old top at the address just read: forward it
	assign below = byp_flag_q ? byp_q : rdata;

	always_comb begin
		mode_b = item_s1.text_start ? bbc_pkg::MODE_NORMAL : mode_q;
		cnt_b  = item_s1.text_start ? '0 : cnt_q;
		line_b = item_s1.text_start ? LINE_BITS'(1) : line_q;
		line_d = (ch == bbc_pkg::CH_NL && line_b != '1) ? line_b + LINE_BITS'(1) : line_b;

		mode_d  = mode_b;
		is_text = 1'b0;
		case (mode_b)
			bbc_pkg::MODE_LINE: begin
				if (ch == bbc_pkg::CH_NL) mode_d = bbc_pkg::MODE_NORMAL;
			end
			bbc_pkg::MODE_BLOCK: begin
				if (ch == bbc_pkg::CH_STAR) mode_d = bbc_pkg::MODE_BLOCK_STAR;
			end
			bbc_pkg::MODE_BLOCK_STAR: begin
				if (ch == bbc_pkg::CH_SLASH) mode_d = bbc_pkg::MODE_NORMAL;
				else if (ch != bbc_pkg::CH_STAR) mode_d = bbc_pkg::MODE_BLOCK;
			end
			bbc_pkg::MODE_SLASH: begin
				if (ch == bbc_pkg::CH_SLASH) begin
					mode_d = bbc_pkg::MODE_LINE;
				end else if (ch == bbc_pkg::CH_STAR) begin
					mode_d = bbc_pkg::MODE_BLOCK;
				end else begin
					mode_d  = bbc_pkg::MODE_NORMAL;
					is_text = 1'b1;
				end
			end
			default: begin
				if (ch == bbc_pkg::CH_SLASH) begin
					mode_d = bbc_pkg::MODE_SLASH;
				end else begin
					mode_d  = bbc_pkg::MODE_NORMAL;
					is_text = 1'b1;
				end
			end
		endcase

		cnt_d = cnt_b;
		top_d = top_q;
		push  = 1'b0;
		we_c  = 1'b0;
		err_v = 1'b0;
		err_k = bbc_pkg::ERR_EMPTY;
		if (is_text) begin
			if (oc != bbc_pkg::BR_NONE) begin
				if (cnt_b == CW'(STACK_DEPTH)) begin
					err_v = 1'b1;
					err_k = bbc_pkg::ERR_OVERFLOW;
				end else begin
					push  = 1'b1;
					we_c  = (cnt_b != '0);
					cnt_d = cnt_b + CW'(1);
					top_d = oc;
				end
			end else if (cc != bbc_pkg::BR_NONE) begin
				if (cnt_b == '0) begin
					err_v = 1'b1;
					err_k = bbc_pkg::ERR_EMPTY;
				end else begin
					// pop even on a mismatch
					cnt_d = cnt_b - CW'(1);
					top_d = below;
					if (top_q != cc) begin
						err_v = 1'b1;
						err_k = bbc_pkg::ERR_MISMATCH;
					end
				end
			end
		end

		cnt_m1 = cnt_b - CW'(1);
		cnt_nx = adv ? cnt_d : cnt_q;
		// prefetch the entry below the next top
		rd_tmp = cnt_nx - CW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= bbc_pkg::MODE_NORMAL;
			cnt_q      <= '0;
			line_q     <= LINE_BITS'(1);
			byp_flag_q <= 1'b0;
		end else begin
			byp_flag_q <= adv && push;
			if (adv) begin
				mode_q <= mode_d;
				cnt_q  <= cnt_d;
				line_q <= line_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_q <= top_d;
			if (push) byp_q <= top_q;
		end
	end

	bbc_ram #(
		.WIDTH (2),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (adv && we_c),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (top_q),
		.raddr (rd_tmp[AW-1:0]),
		.rdata (rdata)
	);

	assign line_ext        = 32'(line_d);
	assign res_valid       = adv && err_v;
	assign res.error_kind  = err_k;
	assign res.line_number = line_ext[bbc_pkg::OUT_LINE_BITS-1:0];
	assign res.found_char  = ch;

endmodule

`default_nettype wire

// File: rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker: core plus output slice.
// Depends on bbc_pkg, bbc_core and bbc_out_slice.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    bbc_pkg::item_t   (text_start, char_in)
//   result    out        result_valid / result_stall bbc_pkg::result_t (kind, line, char)
//
// One byte per clock while item_stall is low. A byte is held in the input register and its
// result, if any, is registered in the output register or its skid entry. The rate is set by
// the stack: the top sits in a register while the RAM prefetches the entry below it.
// Reset empties the stack, sets the line count to one and the mode to normal text.
// item_stall rises only when the input register holds a byte and both output entries are full.
`default_nettype none

module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
	parameter int LINE_BITS   = bbc_pkg::LINE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire bbc_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output bbc_pkg::result_t      result
);

	logic             res_valid;
	logic             res_ready;
	bbc_pkg::result_t res;

	bbc_core #(
		.STACK_DEPTH (STACK_DEPTH),
		.LINE_BITS   (LINE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	bbc_out_slice u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// core never hands a result to a full slice
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result produced while output slice full");

	// after a result is produced, result_valid is high in the next cycle
	a_res_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> result_valid)
		else $error("produced result not presented");

	a_res_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.line_number != '0 || LINE_BITS > bbc_pkg::OUT_LINE_BITS)
			&& (result.error_kind == bbc_pkg::ERR_EMPTY
			|| result.error_kind == bbc_pkg::ERR_MISMATCH
			|| result.error_kind == bbc_pkg::ERR_OVERFLOW))
		else $error("result carries an impossible field value");

	// with the output slice empty, input never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |=> !item_stall)
		else $error("input stalled while output empty");

endmodule

`default_nettype wire
